// ===== hdl/lcs_pkg.sv =====
// Shared types, codes and command-list tables for the line clean sequencer.
// No dependencies; the front, queue, back and top files import this package.
package lcs_pkg;

  // Reset values of the phase-length registers, in ticks.
  localparam logic [15:0] LCS_SETUP_TICKS_RST = 16'd5000;
  localparam logic [15:0] LCS_PHASE_TICKS_RST = 16'd20000;

  // Default depth of the job queue between the front and the back.
  localparam int LCS_QUEUE_DEPTH = 4;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_FULL   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SETUP = 2'd0;
  localparam logic [1:0] REG_RINSE = 2'd1;
  localparam logic [1:0] REG_DOSE  = 2'd2;
  localparam logic [1:0] REG_PURGE = 2'd3;

  // Phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETUP1    = 3'd1;
  localparam logic [2:0] PH_SETUP_FWD = 3'd2;
  localparam logic [2:0] PH_SETUP_REV = 3'd3;
  localparam logic [2:0] PH_RINSE1    = 3'd4;
  localparam logic [2:0] PH_DOSE      = 3'd5;
  localparam logic [2:0] PH_RINSE2    = 3'd6;
  localparam logic [2:0] PH_PURGE     = 3'd7;

  // Channel command states.
  localparam logic [1:0] CS_IDLE      = 2'd1;
  localparam logic [1:0] CS_BUS       = 2'd2;
  localparam logic [1:0] CS_DRAIN_ADJ = 2'd3;

  // Command units.
  localparam logic UNIT_BANK  = 1'b0;
  localparam logic UNIT_DRAIN = 1'b1;

  // Command lists that a job can carry.
  localparam logic [2:0] LIST_NONE   = 3'd0;
  localparam logic [2:0] LIST_IDLE   = 3'd1;
  localparam logic [2:0] LIST_SINGLE = 3'd2;
  localparam logic [2:0] LIST_FWD    = 3'd3;
  localparam logic [2:0] LIST_REV    = 3'd4;

  // One classified input transaction, as queued for the back part.
  typedef struct packed {
    logic       gas;
    logic       pump;
    logic       water;
    logic       idle;
    logic       acc;
    logic [2:0] list;
    logic [1:0] chan;
  } lcs_job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } lcs_qstat_t;

  // One channel command.
  typedef struct packed {
    logic       unit;
    logic [1:0] index;
    logic [1:0] state;
  } lcs_cmd_t;

  // Number of results a job produces.
  function automatic logic [2:0] list_len(input logic [2:0] list);
    logic [2:0] n;
    case (list)
      LIST_IDLE, LIST_FWD, LIST_REV: n = 3'd5;
      default:                       n = 3'd1;
    endcase
    return n;
  endfunction

  // Command k of a list; the empty list gives all zeros.
  function automatic lcs_cmd_t list_cmd(input logic [2:0] list, input logic [2:0] k,
                                        input logic [1:0] chan);
    lcs_cmd_t c;
    c = '0;
    case (list)
      LIST_IDLE: begin
        if (k < 3'd4) c = '{UNIT_BANK, k[1:0], CS_IDLE};
        else c = '{UNIT_DRAIN, 2'd0, CS_IDLE};
      end
      LIST_SINGLE: begin
        c = '{UNIT_BANK, chan, CS_BUS};
      end
      LIST_FWD: begin
        if (k == 3'd0) c = '{UNIT_BANK, 2'd0, CS_BUS};
        else if (k < 3'd4) c = '{UNIT_BANK, k[1:0], CS_DRAIN_ADJ};
        else c = '{UNIT_DRAIN, 2'd0, CS_DRAIN_ADJ};
      end
      LIST_REV: begin
        if (k < 3'd3) c = '{UNIT_BANK, k[1:0], CS_DRAIN_ADJ};
        else if (k == 3'd3) c = '{UNIT_BANK, 2'd3, CS_BUS};
        else c = '{UNIT_DRAIN, 2'd0, CS_IDLE};
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/lcs_channels.sv =====
// Handshake channel interfaces of the line clean sequencer: input, result
// and configuration channels. No dependencies.
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] channel_index;
  modport source (output valid, output opcode, output channel_index, input ready);
  modport sink   (input valid, input opcode, input channel_index, output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic       gas_valve;
  logic       pump_valve;
  logic       water_valve;
  logic       is_idle;
  logic       accepted;
  logic       cmd_valid;
  logic       cmd_unit;
  logic [1:0] cmd_index;
  logic [1:0] cmd_state;
  logic       last;
  modport source (output valid, output gas_valve, output pump_valve, output water_valve,
                  output is_idle, output accepted, output cmd_valid, output cmd_unit,
                  output cmd_index, output cmd_state, output last, input ready);
  modport sink   (input valid, input gas_valve, input pump_valve, input water_valve,
                  input is_idle, input accepted, input cmd_valid, input cmd_unit,
                  input cmd_index, input cmd_state, input last, output ready);
endinterface

interface lcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lcs_front.sv =====
// Front part: configuration registers, phase state and classification of
// each input transaction into a queued job. Depends on lcs_pkg, lcs_channels.
module lcs_front
  import lcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lcs_in_if.sink      in_bus,
  lcs_cfg_if.sink     cfg_bus,
  input  lcs_qstat_t  qstat,
  output logic        push,
  output lcs_job_t    push_job
);

  logic [15:0] setup_ticks_r, rinse_ticks_r, dose_ticks_r, purge_ticks_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        kind_r, kind_nxt;
  logic        rev_r, rev_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [15:0] len;
  logic [15:0] timer_inc;
  logic        enter_en;
  logic [2:0]  enter_ph;
  logic        acc;
  logic [2:0]  list;
  logic        accept;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !qstat.full;
  assign accept        = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_ticks_r <= LCS_SETUP_TICKS_RST;
      rinse_ticks_r <= LCS_PHASE_TICKS_RST;
      dose_ticks_r  <= LCS_PHASE_TICKS_RST;
      purge_ticks_r <= LCS_PHASE_TICKS_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_SETUP: setup_ticks_r <= cfg_bus.data;
        REG_RINSE: rinse_ticks_r <= cfg_bus.data;
        REG_DOSE:  dose_ticks_r  <= cfg_bus.data;
        REG_PURGE: purge_ticks_r <= cfg_bus.data;
        default:   setup_ticks_r <= setup_ticks_r;
      endcase
    end
  end

  always_comb begin
    case (phase_r)
      PH_SETUP1, PH_SETUP_FWD, PH_SETUP_REV: len = setup_ticks_r;
      PH_RINSE1, PH_RINSE2:                  len = rinse_ticks_r;
      PH_DOSE:                               len = dose_ticks_r;
      default:                               len = purge_ticks_r;
    endcase
  end

  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    kind_nxt  = kind_r;
    rev_nxt   = rev_r;
    chan_nxt  = chan_r;
    enter_en  = 1'b0;
    enter_ph  = PH_IDLE;
    acc       = 1'b0;
    list      = LIST_NONE;

    case (in_bus.opcode)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          // A zero length is covered too: the incremented count is at least one.
          if (timer_inc >= len) begin
            enter_en = 1'b1;
            case (phase_r)
              PH_SETUP1, PH_SETUP_FWD, PH_SETUP_REV: enter_ph = PH_RINSE1;
              PH_RINSE1: enter_ph = PH_DOSE;
              PH_DOSE:   enter_ph = PH_RINSE2;
              PH_RINSE2: enter_ph = PH_PURGE;
              default:   enter_ph = (kind_r && !rev_r) ? PH_SETUP_REV : PH_IDLE;
            endcase
          end else begin
            timer_nxt = timer_inc;
          end
        end
      end
      OP_SINGLE: begin
        if (phase_r == PH_IDLE) begin
          acc      = 1'b1;
          chan_nxt = in_bus.channel_index;
          enter_en = 1'b1;
          enter_ph = PH_SETUP1;
        end
      end
      OP_FULL: begin
        if (phase_r == PH_IDLE) begin
          acc      = 1'b1;
          enter_en = 1'b1;
          enter_ph = PH_SETUP_FWD;
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase

    if (enter_en) begin
      phase_nxt = enter_ph;
      timer_nxt = 16'd0;
      case (enter_ph)
        PH_IDLE: list = LIST_IDLE;
        PH_SETUP1: begin
          kind_nxt = 1'b0;
          list     = LIST_SINGLE;
        end
        PH_SETUP_FWD: begin
          kind_nxt = 1'b1;
          rev_nxt  = 1'b0;
          list     = LIST_FWD;
        end
        PH_SETUP_REV: begin
          kind_nxt = 1'b1;
          rev_nxt  = 1'b1;
          list     = LIST_REV;
        end
        default: list = LIST_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= 16'd0;
      kind_r  <= 1'b0;
      rev_r   <= 1'b0;
      chan_r  <= 2'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      kind_r  <= kind_nxt;
      rev_r   <= rev_nxt;
      chan_r  <= chan_nxt;
    end
  end

  assign push           = accept;
  assign push_job.gas   = (phase_nxt == PH_PURGE);
  assign push_job.pump  = (phase_nxt == PH_DOSE);
  assign push_job.water = (phase_nxt == PH_RINSE1) || (phase_nxt == PH_DOSE) ||
                          (phase_nxt == PH_RINSE2);
  assign push_job.idle  = (phase_nxt == PH_IDLE);
  assign push_job.acc   = acc;
  assign push_job.list  = list;
  assign push_job.chan  = chan_nxt;

endmodule

// ===== hdl/lcs_queue.sv =====
// Small job queue that decouples the front from the back.
// Depends on lcs_pkg.
module lcs_queue
  import lcs_pkg::*;
#(
  parameter int DEPTH = LCS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lcs_job_t   push_job,
  input  logic       pop,
  output lcs_job_t   head_job,
  output lcs_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lcs_job_t      slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign qstat.full  = (count_r == FULL_CNT);
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_job    = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
  end

endmodule

// ===== hdl/lcs_back.sv =====
// Back part: expands each queued job into its results and drives the result
// channel from an output register. Depends on lcs_pkg, lcs_channels.
module lcs_back
  import lcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lcs_job_t    head_job,
  input  lcs_qstat_t  qstat,
  output logic        pop,
  lcs_out_if.source   out_bus
);

  logic [2:0] k_r;
  logic       ov_r;
  logic       load;
  logic       fin;
  lcs_cmd_t   cmd;
  logic       gas_r, pump_r, water_r, idle_r, acc_r, cv_r, unit_r, last_r;
  logic [1:0] index_r, state_r;

  assign load = !ov_r || out_bus.ready;
  assign fin  = (k_r + 3'd1 == list_len(head_job.list));
  assign cmd  = list_cmd(head_job.list, k_r, head_job.chan);
  assign pop  = load && !qstat.empty && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= 3'd0;
    end else if (load) begin
      ov_r <= !qstat.empty;
      if (!qstat.empty) k_r <= fin ? 3'd0 : k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      gas_r   <= head_job.gas;
      pump_r  <= head_job.pump;
      water_r <= head_job.water;
      idle_r  <= head_job.idle;
      acc_r   <= head_job.acc;
      cv_r    <= (head_job.list != LIST_NONE);
      unit_r  <= cmd.unit;
      index_r <= cmd.index;
      state_r <= cmd.state;
      last_r  <= fin;
    end
  end

  assign out_bus.valid       = ov_r;
  assign out_bus.gas_valve   = gas_r;
  assign out_bus.pump_valve  = pump_r;
  assign out_bus.water_valve = water_r;
  assign out_bus.is_idle     = idle_r;
  assign out_bus.accepted    = acc_r;
  assign out_bus.cmd_valid   = cv_r;
  assign out_bus.cmd_unit    = unit_r;
  assign out_bus.cmd_index   = index_r;
  assign out_bus.cmd_state   = state_r;
  assign out_bus.last        = last_r;

`ifndef SYNTHESIS
  // A result without a command is always the only one of its transaction.
  a_nocmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !cv_r |-> last_r) else $error("result without command not last");
  // Idle results never open a valve.
  a_idle_closed: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && idle_r |-> !gas_r && !pump_r && !water_r) else $error("valve open in idle");
  // The rest of a command list follows without a gap.
  a_list_cont: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && cv_r && !last_r && out_bus.ready |=> ov_r && cv_r)
    else $error("command list broken");
  // A list in progress keeps its job at the queue head.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != 3'd0 |-> !qstat.empty) else $error("list counter without job");
`endif

endmodule

// ===== hdl/line_clean_sequencer.sv =====
// Line clean sequencer: one result per transaction, five when idle or a full-clean setup is entered.
// The job of an accepted transaction is written to the job queue; its results then pass through the output register.
// Throughput: one transaction per clock while the job queue has room; the result port
// emits one result per clock while the sink is ready; a five-command list takes five results.
// Reset (rst_n, synchronous, active low): idle phase, default phase lengths, empty queue, no results.
module line_clean_sequencer
  import lcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = LCS_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  lcs_in_if.sink    in_bus,
  lcs_out_if.source out_bus,
  lcs_cfg_if.sink   cfg_bus
);

  // The front updates the phase state as soon as a transaction is accepted and
  // queues a job that carries the valve levels and which command list to send.
  // The back walks that list one result per clock while the sink is ready, so a slow
  // result sink only stalls the input once the queue is full.
  lcs_job_t   push_job;
  lcs_job_t   head_job;
  lcs_qstat_t qstat;
  logic       push;
  logic       pop;

  lcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .cfg_bus  (cfg_bus),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  // Jobs wait here in order; the input side is ready whenever a slot is free.
  lcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  // The head job is released only when its last result enters the output register.
  lcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .qstat    (qstat),
    .pop      (pop),
    .out_bus  (out_bus)
  );

endmodule
